### rtl/ir_value_file_alu_core_assert.svh
// Assertion macros for the IR value file ALU core.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef IR_VALUE_FILE_ALU_CORE_ASSERT_SVH
`define IR_VALUE_FILE_ALU_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IVFA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IVFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ivfa_pkg.sv
// Shared types and codes for the IR value file ALU core.
// No dependencies; imported by the ALU and the top level.
package ivfa_pkg;

    localparam int SLOT_IDX_N = 256;

    localparam logic [6:0] MAX_WIDTH = 7'd64;

    localparam logic [4:0] KIND_CONST   = 5'd0;
    localparam logic [4:0] KIND_NOP     = 5'd1;
    localparam logic [4:0] KIND_ADD     = 5'd2;
    localparam logic [4:0] KIND_SUB     = 5'd3;
    localparam logic [4:0] KIND_MUL     = 5'd4;
    localparam logic [4:0] KIND_AND     = 5'd5;
    localparam logic [4:0] KIND_OR      = 5'd6;
    localparam logic [4:0] KIND_XOR     = 5'd7;
    localparam logic [4:0] KIND_NOT     = 5'd8;
    localparam logic [4:0] KIND_SHL     = 5'd9;
    localparam logic [4:0] KIND_LSR     = 5'd10;
    localparam logic [4:0] KIND_ASR     = 5'd11;
    localparam logic [4:0] KIND_ROR     = 5'd12;
    localparam logic [4:0] KIND_TRUNC   = 5'd13;
    localparam logic [4:0] KIND_ZEXT    = 5'd14;
    localparam logic [4:0] KIND_SEXT    = 5'd15;
    localparam logic [4:0] KIND_EQ      = 5'd16;
    localparam logic [4:0] KIND_NE      = 5'd17;
    localparam logic [4:0] KIND_ULT     = 5'd18;
    localparam logic [4:0] KIND_SLT     = 5'd19;
    localparam logic [4:0] KIND_SELECT  = 5'd20;
    localparam logic [4:0] KIND_ADDC    = 5'd21;
    localparam logic [4:0] KIND_SUBC    = 5'd22;
    localparam logic [4:0] KIND_ADDV    = 5'd23;
    localparam logic [4:0] KIND_SUBV    = 5'd24;
    localparam logic [4:0] KIND_BITCAST = 5'd25;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_UNSUP = 2'd3;

    typedef struct packed {
        logic [4:0]  kind;
        logic [6:0]  result_width;
        logic [6:0]  operand_width;
        logic        vec;
        logic [63:0] const_lo;
        logic [63:0] const_hi;
        logic        limit_hit;
    } op_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        store;
        logic        is_mul;
        logic [63:0] value;
        logic [31:0] cross_lh;
        logic [31:0] cross_hl;
        logic [63:0] rmask;
        logic [63:0] hi;
    } res_t;

endpackage

### rtl/ivfa_slot_mem.sv
// Value and high-half slot memories with one write port and three read ports.
// Standalone; instantiated by the top level.
module ivfa_slot_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [63:0]   wr_value,
    input  logic [63:0]   wr_hi,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    input  logic [AW-1:0] rd_addr_c,
    output logic [63:0]   rd_a,
    output logic [63:0]   rd_ahi,
    output logic [63:0]   rd_b,
    output logic [63:0]   rd_c
);

    // The pair memory holds {high half, value}; the second holds a value copy.
    logic [127:0] pair_mem  [DEPTH];
    logic [63:0]  value_mem [DEPTH];

    logic [127:0] rd_pair_a_reg;
    logic [63:0]  rd_b_reg;
    logic [63:0]  rd_c_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            pair_mem[wr_addr] <= {wr_hi, wr_value};
        end
        rd_pair_a_reg <= pair_mem[rd_addr_a];
        rd_b_reg      <= pair_mem[rd_addr_b][63:0];
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            value_mem[wr_addr] <= wr_value;
        end
        rd_c_reg <= value_mem[rd_addr_c];
    end

    assign rd_a   = rd_pair_a_reg[63:0];
    assign rd_ahi = rd_pair_a_reg[127:64];
    assign rd_b   = rd_b_reg;
    assign rd_c   = rd_c_reg;

endmodule

### rtl/ivfa_alu.sv
// Execute logic for one IR operation on forwarded operands.
// Depends on ivfa_pkg for operation codes and the op_t and res_t types.
module ivfa_alu (
    input  ivfa_pkg::op_t  op,
    input  logic [63:0]    a,
    input  logic [63:0]    b,
    input  logic [63:0]    c,
    input  logic [63:0]    ahi,
    output ivfa_pkg::res_t res
);
    import ivfa_pkg::*;

    function automatic logic [63:0] width_mask(input logic [6:0] w);
        if (w >= MAX_WIDTH) begin
            return {64{1'b1}};
        end
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic top_bit(input logic [63:0] x, input logic [6:0] w);
        logic [6:0] p;
        p = w - 7'd1;
        return (w != 7'd0) && x[p[5:0]];
    endfunction

    logic [63:0] mul_ll;
    logic [31:0] cross_lh;
    logic [31:0] cross_hl;

    // The low product is finished in the next stage from these partial products.
    assign mul_ll   = 64'(a[31:0]) * 64'(b[31:0]);
    assign cross_lh = a[31:0] * b[63:32];
    assign cross_hl = a[63:32] * b[31:0];

    always_comb begin
        logic [6:0]  rw;
        logic [6:0]  ow;
        logic [63:0] om;
        logic [63:0] rm;
        logic [63:0] v;
        logic [63:0] hi;
        logic [63:0] sum;
        logic [63:0] diff;
        logic [63:0] fill;
        logic [5:0]  sh;
        logic        shift_bad;
        logic        ls;
        logic        rs;
        logic [1:0]  status;
        logic        store;
        logic        is_mul;

        rw        = (op.result_width > MAX_WIDTH) ? MAX_WIDTH : op.result_width;
        ow        = (op.operand_width > MAX_WIDTH) ? MAX_WIDTH : op.operand_width;
        om        = width_mask(ow);
        rm        = op.vec ? {64{1'b1}} : width_mask(rw);
        sh        = b[5:0];
        shift_bad = (b >= {57'd0, rw});
        sum       = (a + b) & om;
        diff      = (a - b) & om;
        fill      = ((sh != 6'd0) && top_bit(a, rw)) ?
                    ({64{1'b1}} << (rw - {1'b0, sh})) : 64'd0;
        ls        = top_bit(a, ow);
        rs        = top_bit(b, ow);
        v         = 64'd0;
        hi        = 64'd0;
        status    = ST_OK;
        store     = 1'b1;
        is_mul    = 1'b0;

        case (op.kind)
            KIND_CONST: begin
                v  = op.const_lo;
                hi = op.const_hi;
            end
            KIND_NOP:    store = 1'b0;
            KIND_ADD:    v = a + b;
            KIND_SUB:    v = a - b;
            KIND_MUL: begin
                v      = mul_ll;
                is_mul = 1'b1;
            end
            KIND_AND:    v = a & b;
            KIND_OR:     v = a | b;
            KIND_XOR:    v = a ^ b;
            KIND_NOT:    v = ~a;
            KIND_SHL:    v = a << sh;
            KIND_LSR:    v = a >> sh;
            KIND_ASR:    v = (a >> sh) | fill;
            KIND_ROR: begin
                v = (sh == 6'd0) ? a : ((a >> sh) | (a << (rw - {1'b0, sh})));
            end
            KIND_TRUNC:  v = a;
            KIND_ZEXT:   v = a;
            KIND_SEXT:   v = ls ? (a | ~om) : a;
            KIND_EQ:     v = {63'd0, a == b};
            KIND_NE:     v = {63'd0, a != b};
            KIND_ULT:    v = {63'd0, a < b};
            KIND_SLT:    v = {63'd0, (ls != rs) ? ls : (a < b)};
            KIND_SELECT: v = (a != 64'd0) ? b : c;
            KIND_ADDC:   v = {63'd0, sum < (a & om)};
            KIND_SUBC:   v = {63'd0, (a & om) >= (b & om)};
            KIND_ADDV:   v = {63'd0, top_bit(~(a ^ b) & (a ^ sum), ow)};
            KIND_SUBV:   v = {63'd0, top_bit((a ^ b) & (a ^ diff), ow)};
            KIND_BITCAST: begin
                v  = a;
                hi = op.vec ? ahi : 64'd0;
            end
            default: begin
                status = ST_UNSUP;
                store  = 1'b0;
            end
        endcase

        if ((op.kind == KIND_SHL || op.kind == KIND_LSR || op.kind == KIND_ASR ||
             op.kind == KIND_ROR) && shift_bad) begin
            status = ST_SHIFT;
            store  = 1'b0;
        end

        if (op.limit_hit) begin
            status = ST_LIMIT;
            store  = 1'b0;
        end

        if (!store) begin
            is_mul = 1'b0;
            v      = 64'd0;
            hi     = 64'd0;
        end else if (!is_mul) begin
            v = v & rm;
        end

        res.status   = status;
        res.store    = store;
        res.is_mul   = is_mul;
        res.value    = v;
        res.cross_lh = cross_lh;
        res.cross_hl = cross_hl;
        res.rmask    = rm;
        res.hi       = hi;
    end

endmodule

### rtl/ir_value_file_alu_core.sv
// The core executes one IR integer operation per accepted word and returns one
// result word with a status and the value stored into the destination slot. It
// takes a new word every cycle unless the output or a multiply hazard stalls it.
// The read/execute stage reads the slots and executes, and the complete stage
// finishes a multiply and writes the value back. A word that reads the slot written
// by the multiply directly ahead of it waits until that multiply leaves the
// complete stage; all other results are forwarded. The user writes the operation
// limit through the configuration port while idle; the core does not enforce it.
// Top level: operation counter, read/execute/complete pipeline and forwarding.
// Depends on ivfa_pkg, ivfa_slot_mem, ivfa_alu and the assertion macro header.
`include "ir_value_file_alu_core_assert.svh"

module ir_value_file_alu_core #(
    parameter int VALUE_SLOTS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_kind,
    input  logic [7:0]  s_dest_slot,
    input  logic [7:0]  s_src_a,
    input  logic [7:0]  s_src_b,
    input  logic [7:0]  s_src_c,
    input  logic [6:0]  s_result_width,
    input  logic [6:0]  s_operand_width,
    input  logic        s_result_is_vector,
    input  logic [63:0] s_constant_low,
    input  logic [63:0] s_constant_upper,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_written_value
);
    import ivfa_pkg::*;

    localparam int SLOT_W = $clog2(VALUE_SLOTS);

    logic [SLOT_W-1:0] slot_tbl [SLOT_IDX_N];

    logic        in_acc;
    logic        limit_hit;
    logic        out_free;
    logic        s2_adv;
    logic        s2_free;
    logic        s1_adv;
    logic        s1_free;
    logic        s1_hold;
    logic        hazard;
    logic        wr_en;
    logic        s2_fwd_ok;

    logic [SLOT_W-1:0] in_dest;
    logic [SLOT_W-1:0] in_a;
    logic [SLOT_W-1:0] in_b;
    logic [SLOT_W-1:0] in_c;
    logic [SLOT_W-1:0] rd_addr_a;
    logic [SLOT_W-1:0] rd_addr_b;
    logic [SLOT_W-1:0] rd_addr_c;

    logic [63:0] mem_a;
    logic [63:0] mem_ahi;
    logic [63:0] mem_b;
    logic [63:0] mem_c;
    logic [63:0] opa;
    logic [63:0] opahi;
    logic [63:0] opb;
    logic [63:0] opc;

    op_t  in_op;
    res_t alu_res;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    op_t         s1_op_reg;
    logic [SLOT_W-1:0] s1_dest_reg;
    logic [SLOT_W-1:0] s1_a_reg;
    logic [SLOT_W-1:0] s1_b_reg;
    logic [SLOT_W-1:0] s1_c_reg;

    logic        s2_valid_reg;
    logic        s2_valid_next;
    res_t        s2_res_reg;
    logic [SLOT_W-1:0] s2_dest_reg;
    logic [31:0] s2_mul_hi;
    logic [63:0] s2_final;

    logic        m_valid_reg;
    logic        m_valid_next;
    logic [1:0]  m_status_reg;
    logic [63:0] m_value_reg;

    logic        wb_valid_reg;
    logic [SLOT_W-1:0] wb_addr_reg;
    logic [63:0] wb_value_reg;
    logic [63:0] wb_hi_reg;

    logic [31:0] op_count_reg;
    logic [31:0] op_count_next;
    logic [31:0] op_limit_reg;

    for (genvar gi = 0; gi < SLOT_IDX_N; gi++) begin : g_slot_tbl
        assign slot_tbl[gi] = SLOT_W'(gi % VALUE_SLOTS);
    end

    assign in_dest = slot_tbl[s_dest_slot];
    assign in_a    = slot_tbl[s_src_a];
    assign in_b    = slot_tbl[s_src_b];
    assign in_c    = slot_tbl[s_src_c];

    // Handshake and stage control.
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign s2_adv    = s2_valid_reg && out_free;
    assign s2_free   = !s2_valid_reg || out_free;
    assign hazard    = s1_valid_reg && s2_valid_reg && s2_res_reg.store &&
                       s2_res_reg.is_mul &&
                       (s2_dest_reg == s1_a_reg || s2_dest_reg == s1_b_reg ||
                        s2_dest_reg == s1_c_reg);
    assign s1_adv    = s1_valid_reg && s2_free && !hazard;
    assign s1_free   = !s1_valid_reg || s1_adv;
    assign s1_hold   = s1_valid_reg && !s1_adv;
    assign s_ready   = s1_free;
    assign in_acc    = s_valid && s_ready;
    assign limit_hit = (op_count_reg >= op_limit_reg);
    assign wr_en     = s2_adv && s2_res_reg.store;

    assign s1_valid_next = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = s1_adv ? 1'b1 : (out_free ? 1'b0 : s2_valid_reg);
    assign m_valid_next  = s2_adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign op_count_next = (in_acc && !limit_hit) ? (op_count_reg + 32'd1) : op_count_reg;

    // A stalled word re-reads its own slots so the memory sees every earlier write.
    assign rd_addr_a = s1_hold ? s1_a_reg : in_a;
    assign rd_addr_b = s1_hold ? s1_b_reg : in_b;
    assign rd_addr_c = s1_hold ? s1_c_reg : in_c;

    always_comb begin
        in_op.kind          = s_kind;
        in_op.result_width  = s_result_width;
        in_op.operand_width = s_operand_width;
        in_op.vec           = s_result_is_vector;
        in_op.const_lo      = s_constant_low;
        in_op.const_hi      = s_constant_upper;
        in_op.limit_hit     = limit_hit;
    end

    ivfa_slot_mem #(
        .DEPTH (VALUE_SLOTS),
        .AW    (SLOT_W)
    ) u_slot_mem (
        .clk       (aclk),
        .wr_en     (wr_en),
        .wr_addr   (s2_dest_reg),
        .wr_value  (s2_final),
        .wr_hi     (s2_res_reg.hi),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_addr_c (rd_addr_c),
        .rd_a      (mem_a),
        .rd_ahi    (mem_ahi),
        .rd_b      (mem_b),
        .rd_c      (mem_c)
    );

    // The completing stage holds a finished value except after a multiply.
    assign s2_fwd_ok = s2_valid_reg && s2_res_reg.store && !s2_res_reg.is_mul;
    assign s2_mul_hi = s2_res_reg.value[63:32] + s2_res_reg.cross_lh + s2_res_reg.cross_hl;
    assign s2_final  = s2_res_reg.is_mul ?
                       ({s2_mul_hi, s2_res_reg.value[31:0]} & s2_res_reg.rmask) :
                       s2_res_reg.value;

    function automatic logic [63:0] fwd(input logic [SLOT_W-1:0] addr,
                                        input logic [63:0] mem_val,
                                        input logic [63:0] s2_val,
                                        input logic [63:0] wb_val);
        if (s2_fwd_ok && s2_dest_reg == addr) begin
            return s2_val;
        end
        if (wb_valid_reg && wb_addr_reg == addr) begin
            return wb_val;
        end
        return mem_val;
    endfunction

    assign opa   = fwd(s1_a_reg, mem_a, s2_res_reg.value, wb_value_reg);
    assign opahi = fwd(s1_a_reg, mem_ahi, s2_res_reg.hi, wb_hi_reg);
    assign opb   = fwd(s1_b_reg, mem_b, s2_res_reg.value, wb_value_reg);
    assign opc   = fwd(s1_c_reg, mem_c, s2_res_reg.value, wb_value_reg);

    ivfa_alu u_alu (
        .op  (s1_op_reg),
        .a   (opa),
        .b   (opb),
        .c   (opc),
        .ahi (opahi),
        .res (alu_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            wb_valid_reg <= 1'b0;
            op_count_reg <= 32'd0;
            op_limit_reg <= 32'hFFFF_FFFF;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
            wb_valid_reg <= wr_en;
            op_count_reg <= op_count_next;
            if (cfg_valid && cfg_ready) begin
                op_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_op_reg   <= in_op;
            s1_dest_reg <= in_dest;
            s1_a_reg    <= in_a;
            s1_b_reg    <= in_b;
            s1_c_reg    <= in_c;
        end
        if (s1_adv) begin
            s2_res_reg  <= alu_res;
            s2_dest_reg <= s1_dest_reg;
        end
        if (s2_adv) begin
            m_status_reg <= s2_res_reg.status;
            m_value_reg  <= s2_final;
        end
        if (wr_en) begin
            wb_addr_reg  <= s2_dest_reg;
            wb_value_reg <= s2_final;
            wb_hi_reg    <= s2_res_reg.hi;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_written_value = m_value_reg;

    `IVFA_ASSERT_IMP(a_err_no_write, (s2_adv && s2_res_reg.status != ST_OK), !wr_en, "failed word written to slot memory")
    `IVFA_ASSERT_NEXT(a_write_shown, wr_en, (m_valid_reg && m_status_reg == ST_OK), "slot write without matching result word")
    `IVFA_ASSERT_NEXT(a_count_held, (in_acc && limit_hit), $stable(op_count_reg), "operation count moved past the limit")

endmodule

### bench/ir_value_file_alu_core_tb.sv
// Self-checking testbench for ir_value_file_alu_core: directed and random IR words
// are checked against an in-bench model of the slot file and operation counter.
// Depends on ivfa_pkg and the core RTL only.
`timescale 1ns / 100ps

module ir_value_file_alu_core_tb;
    import ivfa_pkg::*;

    localparam logic [4:0] KIND_UNKNOWN_FIRST = 5'd26;
    localparam logic [4:0] KIND_UNKNOWN_LAST  = 5'd31;
    localparam logic [31:0] LIMIT_NONE        = 32'hFFFF_FFFF;

    typedef struct {
        bit [4:0]  kind;
        bit [7:0]  dest_slot;
        bit [7:0]  src_a;
        bit [7:0]  src_b;
        bit [7:0]  src_c;
        bit [6:0]  result_width;
        bit [6:0]  operand_width;
        bit        result_is_vector;
        bit [63:0] constant_low;
        bit [63:0] constant_upper;
    } alu_word_t;

    typedef struct {
        bit [1:0]  status;
        bit [63:0] value;
    } alu_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [4:0]  s_kind = '0;
    logic [7:0]  s_dest_slot = '0;
    logic [7:0]  s_src_a = '0;
    logic [7:0]  s_src_b = '0;
    logic [7:0]  s_src_c = '0;
    logic [6:0]  s_result_width = '0;
    logic [6:0]  s_operand_width = '0;
    logic        s_result_is_vector = 1'b0;
    logic [63:0] s_constant_low = '0;
    logic [63:0] s_constant_upper = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [63:0] m_written_value;

    bit [63:0]   slot_value [SLOT_IDX_N];
    bit          slot_written [SLOT_IDX_N];
    bit [7:0]    written_slots [$];
    bit [31:0]   op_count = '0;
    bit [31:0]   op_limit = LIMIT_NONE;
    alu_result_t pending_results [$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    bit          gaps_enabled = 1'b1;
    int          hold_cycles = 0;
    int          rx_left = 0;
    int          rx_stall_pct = 0;

    ir_value_file_alu_core u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_dest_slot        (s_dest_slot),
        .s_src_a            (s_src_a),
        .s_src_b            (s_src_b),
        .s_src_c            (s_src_c),
        .s_result_width     (s_result_width),
        .s_operand_width    (s_operand_width),
        .s_result_is_vector (s_result_is_vector),
        .s_constant_low     (s_constant_low),
        .s_constant_upper   (s_constant_upper),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_written_value    (m_written_value)
    );

    always #5 aclk = ~aclk;

    function automatic bit [63:0] width_mask(input int unsigned w);
        if (w >= 64) return '1;
        if (w == 0) return '0;
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic bit sign_of(input bit [63:0] v, input int unsigned w);
        if (w == 0) return 1'b0;
        return v[w - 1];
    endfunction

    function automatic void compute_alu_result(input alu_word_t w);
        alu_result_t r;
        bit [63:0]   va, vb, vc, v, om, sum, diff;
        int unsigned rw, ow, sh;
        bit          store;
        va = slot_value[w.src_a];
        vb = slot_value[w.src_b];
        vc = slot_value[w.src_c];
        rw = 32'((w.result_width > MAX_WIDTH) ? MAX_WIDTH : w.result_width);
        ow = 32'((w.operand_width > MAX_WIDTH) ? MAX_WIDTH : w.operand_width);
        om = width_mask(ow);
        sum = (va + vb) & om;
        diff = (va - vb) & om;
        r.status = ST_OK;
        r.value = '0;
        v = '0;
        store = 1'b1;
        if (op_count >= op_limit) begin
            r.status = ST_LIMIT;
        end else begin
            op_count++;
            case (w.kind)
                KIND_CONST:   v = w.constant_low;
                KIND_NOP:     store = 1'b0;
                KIND_ADD:     v = va + vb;
                KIND_SUB:     v = va - vb;
                KIND_MUL:     v = va * vb;
                KIND_AND:     v = va & vb;
                KIND_OR:      v = va | vb;
                KIND_XOR:     v = va ^ vb;
                KIND_NOT:     v = ~va;
                KIND_SHL, KIND_LSR, KIND_ASR, KIND_ROR: begin
                    if (vb >= 64'(rw)) begin
                        r.status = ST_SHIFT;
                        store = 1'b0;
                    end else begin
                        sh = 32'(vb[5:0]);
                        case (w.kind)
                            KIND_SHL: v = va << sh;
                            KIND_LSR: v = va >> sh;
                            KIND_ASR: begin
                                v = va >> sh;
                                if (sh != 0 && sign_of(va, rw)) v |= ~64'd0 << (rw - sh);
                            end
                            default:  v = (sh == 0) ? va : ((va >> sh) | (va << (rw - sh)));
                        endcase
                    end
                end
                KIND_TRUNC, KIND_ZEXT: v = va;
                KIND_SEXT:    v = sign_of(va, ow) ? (va | ~om) : va;
                KIND_EQ:      v = 64'(va == vb);
                KIND_NE:      v = 64'(va != vb);
                KIND_ULT:     v = 64'(va < vb);
                KIND_SLT:     v = 64'((sign_of(va, ow) != sign_of(vb, ow)) ?
                                      sign_of(va, ow) : (va < vb));
                KIND_SELECT:  v = (va != 0) ? vb : vc;
                KIND_ADDC:    v = 64'(sum < (va & om));
                KIND_SUBC:    v = 64'((va & om) >= (vb & om));
                KIND_ADDV:    v = 64'(sign_of(~(va ^ vb) & (va ^ sum), ow));
                KIND_SUBV:    v = 64'(sign_of((va ^ vb) & (va ^ diff), ow));
                KIND_BITCAST: v = va;
                default: begin
                    r.status = ST_UNSUP;
                    store = 1'b0;
                end
            endcase
            if (store && r.status == ST_OK) begin
                if (!w.result_is_vector) v &= width_mask(rw);
                slot_value[w.dest_slot] = v;
                if (!slot_written[w.dest_slot]) begin
                    slot_written[w.dest_slot] = 1'b1;
                    written_slots.push_back(w.dest_slot);
                end
                r.value = v;
            end
        end
        pending_results.push_back(r);
    endfunction

    function automatic bit [7:0] pick_slot();
        if (written_slots.size() == 0) return '0;
        return written_slots[$urandom_range(0, written_slots.size() - 1)];
    endfunction

    // Shift amounts are whole slot values, so most words take a slot holding a small one.
    function automatic bit [7:0] pick_amount_slot();
        bit [7:0] small_slots [$];
        foreach (written_slots[i])
            if (slot_value[written_slots[i]] < 64'd72) small_slots.push_back(written_slots[i]);
        if (small_slots.size() == 0 || $urandom_range(0, 4) == 0) return pick_slot();
        return small_slots[$urandom_range(0, small_slots.size() - 1)];
    endfunction

    function automatic bit [6:0] pick_width();
        case ($urandom_range(0, 11))
            0:       return 7'd0;
            1, 2:    return MAX_WIDTH;
            3:       return 7'd1;
            4:       return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(65, 127)) : 7'd63;
            5:       return 7'd32;
            6:       return 7'd8;
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic bit [63:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3, 4, 5: return 64'($urandom_range(0, 70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic bit [4:0] pick_kind();
        case ($urandom_range(0, 19))
            0, 1, 2, 3: return KIND_CONST;
            4:          return KIND_NOP;
            5:          return 5'($urandom_range(KIND_UNKNOWN_FIRST, KIND_UNKNOWN_LAST));
            default:    return 5'($urandom_range(KIND_ADD, KIND_BITCAST));
        endcase
    endfunction

    function automatic alu_word_t random_word();
        alu_word_t w;
        w.kind = pick_kind();
        w.dest_slot = 8'($urandom_range(0, 255));
        w.src_a = pick_slot();
        w.src_b = (w.kind inside {[KIND_SHL:KIND_ROR]}) ? pick_amount_slot() : pick_slot();
        w.src_c = pick_slot();
        w.result_width = pick_width();
        w.operand_width = pick_width();
        w.result_is_vector = ($urandom_range(0, 9) == 0);
        w.constant_low = pick_value();
        w.constant_upper = {$urandom, $urandom};
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 50)
            $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_word(input alu_word_t w);
        s_kind <= w.kind;
        s_dest_slot <= w.dest_slot;
        s_src_a <= w.src_a;
        s_src_b <= w.src_b;
        s_src_c <= w.src_c;
        s_result_width <= w.result_width;
        s_operand_width <= w.operand_width;
        s_result_is_vector <= w.result_is_vector;
        s_constant_low <= w.constant_low;
        s_constant_upper <= w.constant_upper;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        compute_alu_result(w);
        if (burst_left > 0) begin
            burst_left--;
        end else if (gaps_enabled) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(0, 12);
        end
    endtask

    task automatic send_directed(input bit [4:0] kind, input bit [7:0] dest, input bit [7:0] a,
                                 input bit [7:0] b, input bit [7:0] c, input bit [6:0] rw,
                                 input bit [6:0] ow, input bit vec, input bit [63:0] value);
        alu_word_t w;
        w.kind = kind;
        w.dest_slot = dest;
        w.src_a = a;
        w.src_b = b;
        w.src_c = c;
        w.result_width = rw;
        w.operand_width = ow;
        w.result_is_vector = vec;
        w.constant_low = value;
        w.constant_upper = {$urandom, $urandom};
        send_word(w);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_op_limit(input bit [31:0] limit);
        cfg_data <= limit;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        op_limit = limit;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed_values();
        send_directed(KIND_CONST, 8'd0, 8'd0, 8'd0, 8'd0, MAX_WIDTH, MAX_WIDTH, 1'b0, '1);
        send_directed(KIND_CONST, 8'd1, 8'd0, 8'd0, 8'd0, 7'd100, 7'd0, 1'b0,
                      64'h8000_0000_0000_0000);
        send_directed(KIND_CONST, 8'd2, 8'd0, 8'd1, 8'd0, 7'd8, 7'd0, 1'b0, 64'd5);
        send_directed(KIND_CONST, 8'd255, 8'd1, 8'd2, 8'd0, 7'd0, 7'd0, 1'b1,
                      64'hA5A5_5A5A_0F0F_F0F0);
        send_directed(KIND_CONST, 8'd3, 8'd2, 8'd1, 8'd0, 7'd0, 7'd127, 1'b0, '1);
        wait_drained();
    endtask

    task automatic run_every_kind();
        for (int k = KIND_NOP; k <= KIND_BITCAST; k++)
            send_directed(5'(k), 8'(16 + k), 8'd0, 8'd2, 8'd1, MAX_WIDTH, 7'd16, 1'b0, '0);
        send_directed(KIND_UNKNOWN_FIRST, 8'd60, 8'd0, 8'd2, 8'd1, MAX_WIDTH, 7'd16, 1'b0, '0);
        send_directed(KIND_UNKNOWN_LAST, 8'd61, 8'd0, 8'd2, 8'd1, MAX_WIDTH, 7'd16, 1'b0, '0);
        wait_drained();
    endtask

    task automatic run_edge_cases();
        send_directed(KIND_SHL, 8'd70, 8'd0, 8'd3, 8'd1, 7'd0, 7'd8, 1'b0, '0);
        send_directed(KIND_LSR, 8'd71, 8'd1, 8'd0, 8'd1, MAX_WIDTH, 7'd8, 1'b0, '0);
        send_directed(KIND_ASR, 8'd72, 8'd0, 8'd2, 8'd1, 7'd8, 7'd8, 1'b0, '0);
        send_directed(KIND_ROR, 8'd73, 8'd1, 8'd2, 8'd0, 7'd100, 7'd8, 1'b0, '0);
        send_directed(KIND_ADDV, 8'd74, 8'd0, 8'd0, 8'd1, MAX_WIDTH, 7'd0, 1'b0, '0);
        send_directed(KIND_SUBC, 8'd75, 8'd2, 8'd0, 8'd1, MAX_WIDTH, 7'd8, 1'b0, '0);
        send_directed(KIND_SLT, 8'd76, 8'd0, 8'd2, 8'd1, 7'd1, MAX_WIDTH, 1'b0, '0);
        send_directed(KIND_SELECT, 8'd77, 8'd3, 8'd0, 8'd2, MAX_WIDTH, 7'd8, 1'b0, '0);
        send_directed(KIND_BITCAST, 8'd78, 8'd255, 8'd0, 8'd1, 7'd4, 7'd8, 1'b1, '0);
        wait_drained();
    endtask

    task automatic run_op_limit();
        write_op_limit(op_count + 32'd6);
        repeat (12) send_word(random_word());
        wait_drained();
        write_op_limit('0);
        repeat (4) send_word(random_word());
        wait_drained();
        write_op_limit(LIMIT_NONE);
    endtask

    task automatic run_backpressure();
        gaps_enabled = 1'b0;
        hold_cycles = 150;
        repeat (40) send_word(random_word());
        gaps_enabled = 1'b1;
        wait_drained();
    endtask

    task automatic run_random_mix(input int count);
        for (int i = 0; i < count; i++) begin
            send_word(random_word());
            if (i % 150 == 149) wait_drained();
        end
        wait_drained();
    endtask

    always @(posedge aclk) begin
        alu_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word", {62'd0, m_status}, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", {62'd0, m_status}, {62'd0, want.status});
                    if (m_written_value !== want.value)
                        report_mismatch("written value", m_written_value, want.value);
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_left = $urandom_range(16, 96);
                    case ($urandom_range(0, 4))
                        0, 1:    rx_stall_pct = 0;
                        2:       rx_stall_pct = 25;
                        3:       rx_stall_pct = 60;
                        default: rx_stall_pct = 90;
                    endcase
                end
                rx_left--;
                m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed_values();
        run_every_kind();
        run_edge_cases();
        run_op_limit();
        run_backpressure();
        run_random_mix(460);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
